// File: rtl/core/exr_pkg.sv
// ----------------------------------------------------------------------------
// exr_pkg
// Shared types and constants for the Euler XYZ vertex rotation pipeline.
// ----------------------------------------------------------------------------
package exr_pkg;

  // Coordinate and trig value formats.
  localparam int COORD_WIDTH = 32;
  localparam int TRIG_WIDTH  = 16;
  // Exact product of a coordinate and a trig value, and the sum of two such.
  localparam int PROD_WIDTH  = COORD_WIDTH + TRIG_WIDTH;
  localparam int SUM_WIDTH   = PROD_WIDTH + 1;

  // Configuration port geometry.
  localparam int CFG_ADDR_WIDTH = 5;
  localparam int CFG_DATA_WIDTH = 32;
  localparam int REG_IDX_WIDTH  = 3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [TRIG_WIDTH-1:0]  trig_t;

  // Register indexes, word addressed on the configuration port.
  typedef enum logic [REG_IDX_WIDTH-1:0] {
    REG_COS_X = 3'd0,
    REG_SIN_X = 3'd1,
    REG_COS_Y = 3'd2,
    REG_SIN_Y = 3'd3,
    REG_COS_Z = 3'd4,
    REG_SIN_Z = 3'd5
  } reg_idx_t;

  // Reset values of the trig registers (identity rotation).
  localparam trig_t TRIG_ONE  = 16'sd16384;
  localparam trig_t TRIG_ZERO = 16'sd0;

  // Trig values for all three axes.
  typedef struct packed {
    trig_t cos_x;
    trig_t sin_x;
    trig_t cos_y;
    trig_t sin_y;
    trig_t cos_z;
    trig_t sin_z;
  } trig_cfg_t;

  // Input item: one vertex.
  typedef struct packed {
    coord_t x_in;
    coord_t y_in;
    coord_t z_in;
  } in_item_t;

  // Result item: one rotated vertex.
  typedef struct packed {
    coord_t x_out;
    coord_t y_out;
    coord_t z_out;
  } out_item_t;

endpackage

// File: rtl/core/exr_cfg_regs.sv
// ----------------------------------------------------------------------------
// exr_cfg_regs
// APB-style register file holding the sine and cosine of each axis.
// ----------------------------------------------------------------------------
module exr_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [exr_pkg::CFG_ADDR_WIDTH-1:0]  paddr,
  input  logic [exr_pkg::CFG_DATA_WIDTH-1:0]  pwdata,
  output logic [exr_pkg::CFG_DATA_WIDTH-1:0]  prdata,
  output logic                                pready,
  output exr_pkg::trig_cfg_t                  trig_cfg
);

  exr_pkg::trig_cfg_t trig_r;
  exr_pkg::trig_cfg_t trig_nxt;
  exr_pkg::reg_idx_t  idx;
  exr_pkg::trig_t     wr_val;
  exr_pkg::trig_t     rd_val;
  logic               wr_en;

  // Registers are word aligned; the two low address bits are ignored.
  assign idx    = exr_pkg::reg_idx_t'(paddr[exr_pkg::CFG_ADDR_WIDTH-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign wr_val = exr_pkg::trig_t'(pwdata[exr_pkg::TRIG_WIDTH-1:0]);
  assign pready = 1'b1;

  // Write decode; indexes past the last register are dropped.
  always_comb begin
    trig_nxt = trig_r;
    if (wr_en) begin
      unique case (idx)
        exr_pkg::REG_COS_X: trig_nxt.cos_x = wr_val;
        exr_pkg::REG_SIN_X: trig_nxt.sin_x = wr_val;
        exr_pkg::REG_COS_Y: trig_nxt.cos_y = wr_val;
        exr_pkg::REG_SIN_Y: trig_nxt.sin_y = wr_val;
        exr_pkg::REG_COS_Z: trig_nxt.cos_z = wr_val;
        exr_pkg::REG_SIN_Z: trig_nxt.sin_z = wr_val;
        default:            trig_nxt = trig_r;
      endcase
    end
  end

  // Register storage with the identity rotation at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_r.cos_x <= exr_pkg::TRIG_ONE;
      trig_r.sin_x <= exr_pkg::TRIG_ZERO;
      trig_r.cos_y <= exr_pkg::TRIG_ONE;
      trig_r.sin_y <= exr_pkg::TRIG_ZERO;
      trig_r.cos_z <= exr_pkg::TRIG_ONE;
      trig_r.sin_z <= exr_pkg::TRIG_ZERO;
    end else begin
      trig_r <= trig_nxt;
    end
  end

  // Read mux; values are returned zero extended.
  always_comb begin
    unique case (idx)
      exr_pkg::REG_COS_X: rd_val = trig_r.cos_x;
      exr_pkg::REG_SIN_X: rd_val = trig_r.sin_x;
      exr_pkg::REG_COS_Y: rd_val = trig_r.cos_y;
      exr_pkg::REG_SIN_Y: rd_val = trig_r.sin_y;
      exr_pkg::REG_COS_Z: rd_val = trig_r.cos_z;
      exr_pkg::REG_SIN_Z: rd_val = trig_r.sin_z;
      default:            rd_val = exr_pkg::TRIG_ZERO;
    endcase
  end

  assign prdata   = {{(exr_pkg::CFG_DATA_WIDTH-exr_pkg::TRIG_WIDTH){1'b0}}, rd_val};
  assign trig_cfg = trig_r;

endmodule

// File: rtl/core/exr_rot_stage.sv
// ----------------------------------------------------------------------------
// exr_rot_stage
// One plane rotation: a' = a*c - b*s, b' = b*c + a*s, floored and saturated.
// Two register levels: products, then sum/shift/saturate. The third
// coordinate rides along unchanged.
// ----------------------------------------------------------------------------
module exr_rot_stage #(
  parameter int FRAC_BITS = 14
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  exr_pkg::coord_t in_a,
  input  exr_pkg::coord_t in_b,
  input  exr_pkg::coord_t in_c,
  input  exr_pkg::trig_t  cos_v,
  input  exr_pkg::trig_t  sin_v,
  output logic            out_valid,
  input  logic            out_ready,
  output exr_pkg::coord_t out_a,
  output exr_pkg::coord_t out_b,
  output exr_pkg::coord_t out_c
);

  localparam int PW = exr_pkg::PROD_WIDTH;
  localparam int SW = exr_pkg::SUM_WIDTH;
  localparam int CW = exr_pkg::COORD_WIDTH;

  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [SW-1:0] sum_t;

  // Floor shift by FRAC_BITS, then clamp to the coordinate range.
  function automatic exr_pkg::coord_t shift_sat(input sum_t v);
    sum_t sh;
    logic all_one;
    logic all_zero;
    exr_pkg::coord_t res;
    sh       = v >>> FRAC_BITS;
    all_one  = &sh[SW-1:CW-1];
    all_zero = ~|sh[SW-1:CW-1];
    if (all_one || all_zero) begin
      res = exr_pkg::coord_t'(sh[CW-1:0]);
    end else if (sh[SW-1]) begin
      res = {1'b1, {(CW-1){1'b0}}};
    end else begin
      res = {1'b0, {(CW-1){1'b1}}};
    end
    return res;
  endfunction

  logic            v1_r, v2_r;
  logic            ready1, ready2;
  prod_t           ac_r, bs_r, bc_r, as_r;
  prod_t           ac_nxt, bs_nxt, bc_nxt, as_nxt;
  exr_pkg::coord_t c1_r, c2_r;
  exr_pkg::coord_t a2_r, b2_r;
  exr_pkg::coord_t a2_nxt, b2_nxt;

  // Backpressure: a level moves when it is empty or its successor moves.
  assign ready2   = !v2_r || out_ready;
  assign ready1   = !v1_r || ready2;
  assign in_ready = ready1;

  // Level 1: four exact products.
  always_comb begin
    ac_nxt = prod_t'(in_a) * prod_t'(cos_v);
    bs_nxt = prod_t'(in_b) * prod_t'(sin_v);
    bc_nxt = prod_t'(in_b) * prod_t'(cos_v);
    as_nxt = prod_t'(in_a) * prod_t'(sin_v);
  end

  // Level 2: exact sums, floor shift and saturation.
  always_comb begin
    a2_nxt = shift_sat(sum_t'(ac_r) - sum_t'(bs_r));
    b2_nxt = shift_sat(sum_t'(bc_r) + sum_t'(as_r));
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (ready1) begin
        v1_r <= in_valid;
      end
      if (ready2) begin
        v2_r <= v1_r;
      end
    end
  end

  // Payload registers, loaded only when a valid item moves in.
  always_ff @(posedge clk) begin
    if (in_valid && ready1) begin
      ac_r <= ac_nxt;
      bs_r <= bs_nxt;
      bc_r <= bc_nxt;
      as_r <= as_nxt;
      c1_r <= in_c;
    end
    if (v1_r && ready2) begin
      a2_r <= a2_nxt;
      b2_r <= b2_nxt;
      c2_r <= c1_r;
    end
  end

  assign out_valid = v2_r;
  assign out_a     = a2_r;
  assign out_b     = b2_r;
  assign out_c     = c2_r;

endmodule

// File: rtl/core/euler_xyz_rotate_vertex_top.sv
// ----------------------------------------------------------------------------
// euler_xyz_rotate_vertex_top
// Rotates a Q16.16 vertex about X, then Y, then Z with programmable Q1.14
// sines and cosines.
// ----------------------------------------------------------------------------
// The block takes one vertex per clock cycle while the output side is not
// stalling. Each vertex passes through three rotation stages in a row, each
// with one multiplier level and one sum, floor-shift and saturate level.
// Stalls ripple back through the valid bits, so no item is lost or repeated,
// and the input only stalls once every level is full. Trig registers should
// be written only while the pipeline is empty.
module euler_xyz_rotate_vertex_top #(
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  exr_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output exr_pkg::out_item_t                  out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [exr_pkg::CFG_ADDR_WIDTH-1:0]  paddr,
  input  logic [exr_pkg::CFG_DATA_WIDTH-1:0]  pwdata,
  output logic [exr_pkg::CFG_DATA_WIDTH-1:0]  prdata,
  output logic                                pready
);

  exr_pkg::trig_cfg_t trig_cfg;
  logic               rdy_x, rdy_y, rdy_z;
  logic               vld_x, vld_y;
  exr_pkg::coord_t    x1, y1, z1;
  exr_pkg::coord_t    x2, y2, z2;

  // Trig register file.
  exr_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .trig_cfg (trig_cfg)
  );

  // Rotation about X: y and z change, x passes.
  exr_rot_stage #(.FRAC_BITS(TRIG_FRAC_BITS)) u_rot_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (rdy_x),
    .in_a      (in_data.y_in),
    .in_b      (in_data.z_in),
    .in_c      (in_data.x_in),
    .cos_v     (trig_cfg.cos_x),
    .sin_v     (trig_cfg.sin_x),
    .out_valid (vld_x),
    .out_ready (rdy_y),
    .out_a     (y1),
    .out_b     (z1),
    .out_c     (x1)
  );

  // Rotation about Y: z and x change, y passes.
  exr_rot_stage #(.FRAC_BITS(TRIG_FRAC_BITS)) u_rot_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld_x),
    .in_ready  (rdy_y),
    .in_a      (z1),
    .in_b      (x1),
    .in_c      (y1),
    .cos_v     (trig_cfg.cos_y),
    .sin_v     (trig_cfg.sin_y),
    .out_valid (vld_y),
    .out_ready (rdy_z),
    .out_a     (z2),
    .out_b     (x2),
    .out_c     (y2)
  );

  // Rotation about Z: x and y change, z passes.
  exr_rot_stage #(.FRAC_BITS(TRIG_FRAC_BITS)) u_rot_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld_y),
    .in_ready  (rdy_z),
    .in_a      (x2),
    .in_b      (y2),
    .in_c      (z2),
    .cos_v     (trig_cfg.cos_z),
    .sin_v     (trig_cfg.sin_z),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .out_a     (out_data.x_out),
    .out_b     (out_data.y_out),
    .out_c     (out_data.z_out)
  );

  assign in_stall = !rdy_x;

  // The input can only stall when the whole pipeline is backed up.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output was free");

  // Reset empties the pipeline.
  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // An empty pipeline never holds off the input.
  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid && !vld_x && !vld_y) |-> !in_stall)
    else $error("input stalled with the pipeline drained");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Euler XYZ vertex rotation pipeline. Vertices
// stream in under random sender gaps and receiver stalls; a local fixed-point
// predictor works out each rotated vertex and the checker compares it field
// by field, in order, with what leaves the block.
// ----------------------------------------------------------------------------
module testbench;

  localparam int FRAC_BITS      = 14;
  localparam int PIPE_LATENCY   = 6;
  localparam int NUM_TRIG_REGS  = 6;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SEGMENT_ITEMS  = 130;
  localparam int SEGMENTS       = 4;

  localparam longint COORD_HI = 64'sd2147483647;
  localparam longint COORD_LO = -64'sd2147483648;
  localparam exr_pkg::coord_t COORD_MAX = 32'sh7FFF_FFFF;
  localparam exr_pkg::coord_t COORD_MIN = 32'sh8000_0000;

  logic                               clk      = 1'b0;
  logic                               rst_n    = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  exr_pkg::in_item_t                  in_data  = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  exr_pkg::out_item_t                 out_data;
  logic                               psel     = 1'b0;
  logic                               penable  = 1'b0;
  logic                               pwrite   = 1'b0;
  logic [exr_pkg::CFG_ADDR_WIDTH-1:0] paddr    = '0;
  logic [exr_pkg::CFG_DATA_WIDTH-1:0] pwdata   = '0;
  logic [exr_pkg::CFG_DATA_WIDTH-1:0] prdata;
  logic                               pready;

  // Trig values as the block should hold them, starting at identity.
  exr_pkg::trig_cfg_t trig_shadow = '{cos_x: exr_pkg::TRIG_ONE, sin_x: exr_pkg::TRIG_ZERO,
                                      cos_y: exr_pkg::TRIG_ONE, sin_y: exr_pkg::TRIG_ZERO,
                                      cos_z: exr_pkg::TRIG_ONE, sin_z: exr_pkg::TRIG_ZERO};
  exr_pkg::out_item_t pending_rotations[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;
  int vertices_sent  = 0;
  int results_seen   = 0;
  int settings_used  = 0;
  int quiet_cycles   = 0;

  euler_xyz_rotate_vertex_top #(
    .TRIG_FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #4 clk = ~clk;

  // One rotation term: exact two-product sum, floor shift, then saturate.
  function automatic longint rot_term(input longint a, input longint ca,
                                      input longint b, input longint cb);
    longint acc;
    acc = (a * ca + b * cb) >>> FRAC_BITS;
    if (acc > COORD_HI) acc = COORD_HI;
    if (acc < COORD_LO) acc = COORD_LO;
    return acc;
  endfunction

  // Rotate about X, then Y, then Z; each stage feeds the next.
  function automatic exr_pkg::out_item_t rotate_xyz(input exr_pkg::in_item_t v);
    longint x, y, z, nx, ny, nz;
    longint cx, sx, cy, sy, cz, sz;
    exr_pkg::out_item_t r;
    x  = v.x_in;  y  = v.y_in;  z  = v.z_in;
    cx = trig_shadow.cos_x;  sx = trig_shadow.sin_x;
    cy = trig_shadow.cos_y;  sy = trig_shadow.sin_y;
    cz = trig_shadow.cos_z;  sz = trig_shadow.sin_z;
    ny = rot_term(y, cx, z, -sx);
    nz = rot_term(z, cx, y, sx);
    y = ny;  z = nz;
    nz = rot_term(z, cy, x, -sy);
    nx = rot_term(x, cy, z, sy);
    z = nz;  x = nx;
    nx = rot_term(x, cz, y, -sz);
    ny = rot_term(y, cz, x, sz);
    x = nx;  y = ny;
    r.x_out = exr_pkg::coord_t'(x);
    r.y_out = exr_pkg::coord_t'(y);
    r.z_out = exr_pkg::coord_t'(z);
    return r;
  endfunction

  // Trig value the block should return for one register index.
  function automatic exr_pkg::trig_t shadow_value(input int idx);
    exr_pkg::trig_t val;
    case (idx)
      exr_pkg::REG_COS_X: val = trig_shadow.cos_x;
      exr_pkg::REG_SIN_X: val = trig_shadow.sin_x;
      exr_pkg::REG_COS_Y: val = trig_shadow.cos_y;
      exr_pkg::REG_SIN_Y: val = trig_shadow.sin_y;
      exr_pkg::REG_COS_Z: val = trig_shadow.cos_z;
      exr_pkg::REG_SIN_Z: val = trig_shadow.sin_z;
      default:            val = exr_pkg::TRIG_ZERO;
    endcase
    return val;
  endfunction

  // Print a failure and count it.
  task automatic log_failure(input string msg);
    $display("[%0t] FAIL: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_coord(input string field, input exr_pkg::coord_t got,
                             input exr_pkg::coord_t want);
    if (got !== want)
      log_failure($sformatf("result %0d %s: got %0d, expected %0d",
                            results_seen, field, got, want));
  endtask

  // Compare one rotated vertex with the oldest expectation.
  task automatic check_rotated(input exr_pkg::out_item_t got);
    exr_pkg::out_item_t want;
    if (pending_rotations.size() == 0) begin
      log_failure($sformatf("result %0d arrived with no vertex outstanding",
                            results_seen));
    end else begin
      want = pending_rotations.pop_front();
      check_coord("x_out", got.x_out, want.x_out);
      check_coord("y_out", got.y_out, want.y_out);
      check_coord("z_out", got.z_out, want.z_out);
    end
    results_seen++;
  endtask

  // Result side: check accepted items and stall at random.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_rotated(out_data);
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog: ends the run if no handshake of any kind happens for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles, %0d vertices outstanding",
                 quiet_cycles, pending_rotations.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Send one vertex after a random gap; expectation is queued on acceptance.
  task automatic send_vertex(input exr_pkg::in_item_t v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= v;
    do @(posedge clk); while (in_stall);
    pending_rotations.push_back(rotate_xyz(v));
    vertices_sent++;
  endtask

  // Hold the input until every result is back, then let the pipe settle.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_rotations.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  // One register write: setup cycle, access cycle until pready, then idle.
  // Upper data bits are random; only the low 16 bits should land.
  task automatic write_reg(input int idx, input exr_pkg::trig_t val);
    logic [exr_pkg::CFG_DATA_WIDTH-1:0] word;
    word = {16'($urandom), val};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= exr_pkg::CFG_ADDR_WIDTH'(4 * idx);
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      exr_pkg::REG_COS_X: trig_shadow.cos_x = exr_pkg::trig_t'(word[15:0]);
      exr_pkg::REG_SIN_X: trig_shadow.sin_x = exr_pkg::trig_t'(word[15:0]);
      exr_pkg::REG_COS_Y: trig_shadow.cos_y = exr_pkg::trig_t'(word[15:0]);
      exr_pkg::REG_SIN_Y: trig_shadow.sin_y = exr_pkg::trig_t'(word[15:0]);
      exr_pkg::REG_COS_Z: trig_shadow.cos_z = exr_pkg::trig_t'(word[15:0]);
      exr_pkg::REG_SIN_Z: trig_shadow.sin_z = exr_pkg::trig_t'(word[15:0]);
      default: ;  // unmapped address, nothing changes
    endcase
  endtask

  // One register read, compared with the zero-extended expected value.
  task automatic check_readback(input int idx);
    logic [exr_pkg::CFG_DATA_WIDTH-1:0] want;
    logic [exr_pkg::CFG_DATA_WIDTH-1:0] got;
    want = {{(exr_pkg::CFG_DATA_WIDTH-exr_pkg::TRIG_WIDTH){1'b0}}, shadow_value(idx)};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= exr_pkg::CFG_ADDR_WIDTH'(4 * idx);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== want)
      log_failure($sformatf("register %0d read back 0x%08h, expected 0x%08h",
                            idx, got, want));
  endtask

  task automatic program_rotation(input exr_pkg::trig_cfg_t c);
    drain_pipeline();
    write_reg(exr_pkg::REG_COS_X, c.cos_x);
    write_reg(exr_pkg::REG_SIN_X, c.sin_x);
    write_reg(exr_pkg::REG_COS_Y, c.cos_y);
    write_reg(exr_pkg::REG_SIN_Y, c.sin_y);
    write_reg(exr_pkg::REG_COS_Z, c.cos_z);
    write_reg(exr_pkg::REG_SIN_Z, c.sin_z);
    settings_used++;
  endtask

  // Field extremes, unit steps and odd LSBs that exercise floor rounding.
  task automatic send_corner_vertices();
    send_vertex('{x_in: COORD_MAX, y_in: COORD_MIN, z_in: 32'sd0});
    send_vertex('{x_in: COORD_MIN, y_in: -32'sd1, z_in: COORD_MAX});
    send_vertex('{x_in: -32'sd1, y_in: 32'sd1, z_in: -32'sd3});
    send_vertex('{x_in: 32'sh0001_0000, y_in: -32'sd32769, z_in: 32'sd5});
  endtask

  function automatic exr_pkg::trig_t rand_trig();
    int t;
    case ($urandom_range(0, 3))
      0, 1: t = int'($urandom_range(0, 32768)) - 16384;
      2: begin
        case ($urandom_range(0, 4))
          0: t = 16384;
          1: t = -16384;
          2: t = 0;
          3: t = 32767;
          default: t = -32768;
        endcase
      end
      default: t = int'($urandom);
    endcase
    return exr_pkg::trig_t'(t);
  endfunction

  function automatic exr_pkg::coord_t rand_coord();
    case ($urandom_range(0, 9))
      6, 7, 8: return exr_pkg::coord_t'(int'($urandom_range(0, 2097152)) - 1048576);
      9: begin
        case ($urandom_range(0, 3))
          0: return COORD_MAX;
          1: return COORD_MIN;
          2: return -32'sd1;
          default: return 32'sd0;
        endcase
      end
      default: return exr_pkg::coord_t'($urandom);
    endcase
  endfunction

  // The reset values must give an exact identity rotation.
  task automatic test_reset_identity();
    send_corner_vertices();
    send_vertex('{x_in: 32'sd0, y_in: 32'sd0, z_in: 32'sd0});
  endtask

  // Out-of-range trig patterns, full-scale sines and saturation.
  task automatic test_trig_extremes();
    program_rotation('{cos_x: -16'sd32768, sin_x: 16'sd0, cos_y: -16'sd32768,
                       sin_y: 16'sd0, cos_z: -16'sd32768, sin_z: 16'sd0});
    send_corner_vertices();
    program_rotation('{cos_x: 16'sd32767, sin_x: -16'sd32768, cos_y: -16'sd16384,
                       sin_y: 16'sd16384, cos_z: 16'sd0, sin_z: -16'sd32768});
    send_corner_vertices();
    // Negative 45 degrees about X, 90 about Y, 180 about Z.
    program_rotation('{cos_x: 16'sd11585, sin_x: -16'sd11585, cos_y: 16'sd0,
                       sin_y: 16'sd16384, cos_z: -16'sd16384, sin_z: 16'sd0});
    send_corner_vertices();
  endtask

  // Writes to the two addresses past the last register must change nothing.
  task automatic test_unmapped_registers();
    drain_pipeline();
    write_reg(NUM_TRIG_REGS, rand_trig());
    write_reg(NUM_TRIG_REGS + 1, rand_trig());
    for (int i = 0; i < NUM_TRIG_REGS; i++) check_readback(i);
    send_corner_vertices();
  endtask

  // Random vertices under random trig settings, three stall mixes.
  task automatic test_random_streams();
    exr_pkg::trig_cfg_t c;
    exr_pkg::in_item_t  v;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 35; recv_stall_pct = 78; end
        1: begin send_idle_pct = 78; recv_stall_pct = 35; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        c.cos_x = rand_trig();  c.sin_x = rand_trig();
        c.cos_y = rand_trig();  c.sin_y = rand_trig();
        c.cos_z = rand_trig();  c.sin_z = rand_trig();
        program_rotation(c);
        for (int n = 0; n < SEGMENT_ITEMS; n++) begin
          v.x_in = rand_coord();
          v.y_in = rand_coord();
          v.z_in = rand_coord();
          send_vertex(v);
        end
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_identity();
    test_trig_extremes();
    test_unmapped_registers();
    test_random_streams();

    drain_pipeline();
    repeat (PIPE_LATENCY * 4) @(posedge clk);
    $display("Rotated %0d vertices under %0d trig settings, %0d results checked.",
             vertices_sent, settings_used, results_seen);
    $display("Covered identity after reset, out-of-range trig, saturation, unmapped writes.");
    if (fail_count == 0 && pending_rotations.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// File: files.f
rtl/core/exr_pkg.sv
rtl/core/exr_cfg_regs.sv
rtl/core/exr_rot_stage.sv
rtl/core/euler_xyz_rotate_vertex_top.sv
dv/testbench.sv
